@@ src/multi_channel_periodic_scheduler_macros.svh @@
// Assertion macros for the multi-channel periodic scheduler.
// No dependencies; included by the checker.
`ifndef MULTI_CHANNEL_PERIODIC_SCHEDULER_MACROS_SVH
`define MULTI_CHANNEL_PERIODIC_SCHEDULER_MACROS_SVH

// same-cycle implication, disabled during reset
`define MCPS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mcps assertion failed");

// next-cycle implication, disabled during reset
`define MCPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mcps assertion failed");

`endif

@@ src/mcps_pkg.sv @@
// Shared constants and types for the multi-channel periodic scheduler.
// No dependencies.
`timescale 1ns / 1ps

package mcps_pkg;

    localparam int NUM_CHANNELS    = 4;
    localparam int TIME_BITS       = 32;
    localparam int PERIOD_W        = 31;
    localparam int MASK_W          = 4;
    localparam int NUM_PERIOD_REGS = 4;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 31;
    localparam int CHAN_OUT_W      = 2;
    localparam int CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CNT_W = $clog2(NUM_CHANNELS + 1);
    localparam int SUM_W = ((TIME_BITS > PERIOD_W) ? TIME_BITS : PERIOD_W) + 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE_MASK = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_BASE = CFG_IDX_W'(1);

    // command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_CHECK = 1'b1;

    typedef logic [TIME_BITS-1:0] tick_t;
    typedef logic [PERIOD_W-1:0]  period_t;
    typedef logic [CH_W-1:0]      chan_t;

    // entry passed around the ring of cells
    typedef struct packed {
        logic  pend;
        tick_t lag;
        chan_t idx;
    } token_t;

    typedef struct packed {
        logic  load_start;
        logic  load_check;
        logic  ring_step;
        logic  emit;
        chan_t emit_cnt;
    } cell_ctrl_t;

    typedef struct packed {
        logic pend;
        logic hit;
    } cell_stat_t;

endpackage

@@ src/mcps_ifs.sv @@
// Channel interfaces: request input, firing output, configuration writes.
// Depends on mcps_pkg.
`timescale 1ns / 1ps

interface mcps_req_if;
    import mcps_pkg::*;
    logic  valid;
    logic  ready;
    logic  command;
    tick_t now_time;
    modport source (output valid, output command, output now_time, input ready);
    modport sink   (input valid, input command, input now_time, output ready);
endinterface

interface mcps_fire_if;
    import mcps_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CHAN_OUT_W-1:0] fired_channel;
    tick_t                 fire_time;
    logic                  last_of_run;
    modport source (output valid, output fired_channel, output fire_time,
                    output last_of_run, input ready);
    modport sink   (input valid, input fired_channel, input fire_time,
                    input last_of_run, output ready);
endinterface

interface mcps_cfg_if;
    import mcps_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/mcps_cell.sv @@
// One channel cell: due time, period, lag and rank, with a ring link to its neighbor.
// Depends on mcps_pkg.
`timescale 1ns / 1ps

module mcps_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  mcps_pkg::cell_ctrl_t ctrl,
    input  mcps_pkg::tick_t     now_time,
    input  mcps_pkg::chan_t     own_idx,
    input  logic                en,
    input  logic                period_we,
    input  mcps_pkg::period_t   period_data,
    input  mcps_pkg::token_t    tok_in,
    output mcps_pkg::token_t    tok_out,
    output mcps_pkg::cell_stat_t stat
);
    import mcps_pkg::*;

    tick_t   due_reg;
    period_t period_reg;
    tick_t   lag_reg;
    logic    pend_reg;
    chan_t   rank_reg;
    token_t  tok_reg;

    tick_t              lag_next;
    logic               pend_next;
    logic               beats;
    logic [SUM_W-1:0]   due_sum;

    assign lag_next  = now_time - due_reg;
    assign pend_next = en && !lag_next[TIME_BITS-1];
    assign due_sum   = SUM_W'(due_reg) + SUM_W'(period_reg);

    // incoming entry is ahead of this one: older due time, or same with lower index
    assign beats = tok_in.pend &&
                   ((tok_in.lag > lag_reg) ||
                    ((tok_in.lag == lag_reg) && (tok_in.idx < own_idx)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            due_reg    <= '0;
            period_reg <= PERIOD_W'(1);
            pend_reg   <= 1'b0;
        end
        else
        begin
            if (period_we)
            begin
                period_reg <= period_data;
            end
            if (ctrl.load_start)
            begin
                due_reg <= now_time;
            end
            else if (ctrl.emit && stat.hit)
            begin
                due_reg <= due_sum[TIME_BITS-1:0];
            end
            if (ctrl.load_check)
            begin
                pend_reg <= pend_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_check)
        begin
            lag_reg  <= lag_next;
            rank_reg <= '0;
            tok_reg  <= '{pend: pend_next, lag: lag_next, idx: own_idx};
        end
        else if (ctrl.ring_step)
        begin
            if (beats)
            begin
                rank_reg <= rank_reg + CH_W'(1);
            end
            tok_reg <= tok_in;
        end
    end

    assign tok_out   = tok_reg;
    assign stat.pend = pend_reg;
    assign stat.hit  = pend_reg && (rank_reg == ctrl.emit_cnt);

endmodule

@@ src/multi_channel_periodic_scheduler.sv @@
// Multi-channel periodic scheduler: a ring of channel cells ranks due channels, then emits.
// Depends on mcps_pkg, mcps_ifs and mcps_cell.
// A check holds off further requests until its ring pass and its firings are done, with
// one firing per cycle while the output is not stalled.
// Start items do not hold the input. Reset clears due times, periods to 1, mask and armed flag.
`timescale 1ns / 1ps

module multi_channel_periodic_scheduler (
    input  logic       clk,
    input  logic       rst_n,
    mcps_req_if.sink   req,
    mcps_fire_if.source fire,
    mcps_cfg_if.sink   cfg
);
    import mcps_pkg::*;

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RING = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    // each cell must see every other entry once: NUM_CHANNELS - 1 ring steps
    localparam int    RING_STEPS = NUM_CHANNELS - 1;
    localparam chan_t RING_LAST  = CH_W'((NUM_CHANNELS > 1) ? NUM_CHANNELS - 2 : 0);

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    chan_t             step_reg;
    chan_t             emit_cnt_reg;
    tick_t             now_reg;
    logic              started_reg;
    logic [MASK_W-1:0] mask_reg;

    // output register
    logic                  out_valid_reg;
    logic [CHAN_OUT_W-1:0] out_chan_reg;
    tick_t                 out_time_reg;
    logic                  out_last_reg;

    logic       req_acc;
    logic       cfg_acc;
    logic       slot_free;
    logic       emit_go;
    logic       is_last;
    cell_ctrl_t ctrl;

    token_t              tok     [NUM_CHANNELS];
    cell_stat_t          stat    [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] pend_vec;
    logic [NUM_CHANNELS-1:0] hit_vec;
    logic [CNT_W-1:0]    due_count;
    chan_t               sel_idx;

    assign req_acc   = req.valid && req.ready;
    assign cfg_acc   = cfg.valid && cfg.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;

    // output stage can take a new firing when empty or being drained
    assign slot_free = !out_valid_reg || fire.ready;
    assign emit_go   = (state_reg == ST_EMIT) && (due_count != '0) && slot_free;
    assign is_last   = ((CNT_W'(emit_cnt_reg) + CNT_W'(1)) == due_count);

    assign ctrl.load_start = req_acc && (req.command == CMD_START);
    // checks before the first start are dropped
    assign ctrl.load_check = req_acc && (req.command == CMD_CHECK) && started_reg;
    assign ctrl.ring_step  = (state_reg == ST_RING);
    assign ctrl.emit       = emit_go;
    assign ctrl.emit_cnt   = emit_cnt_reg;

    // ring of cells: cell c hears from cell c-1, cell 0 from the last one
    for (genvar c = 0; c < NUM_CHANNELS; c++)
    begin : g_cell
        localparam int PREV = (c == 0) ? NUM_CHANNELS - 1 : c - 1;
        logic en_bit;
        logic pwe;

        if (c < MASK_W)
        begin : g_en
            assign en_bit = mask_reg[c];
        end
        else
        begin : g_no_en
            assign en_bit = 1'b0;
        end

        if (c < NUM_PERIOD_REGS)
        begin : g_pwe
            assign pwe = cfg_acc && (cfg.index == REG_PERIOD_BASE + CFG_IDX_W'(c));
        end
        else
        begin : g_no_pwe
            assign pwe = 1'b0;
        end

        mcps_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .now_time    (req.now_time),
            .own_idx     (CH_W'(c)),
            .en          (en_bit),
            .period_we   (pwe),
            .period_data (PERIOD_W'(cfg.data)),
            .tok_in      (tok[PREV]),
            .tok_out     (tok[c]),
            .stat        (stat[c])
        );

        assign pend_vec[c] = stat[c].pend;
        assign hit_vec[c]  = stat[c].hit;
    end

    assign due_count = CNT_W'($countones(pend_vec));

    // exactly one due cell holds the current rank during emission
    always_comb
    begin
        sel_idx = '0;
        for (int c = 0; c < NUM_CHANNELS; c++)
        begin
            if (hit_vec[c])
            begin
                sel_idx = sel_idx | CH_W'(c);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (ctrl.load_check)
                begin
                    state_next = (RING_STEPS > 0) ? ST_RING : ST_EMIT;
                end
            end
            ST_RING:
            begin
                if (step_reg == RING_LAST)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (due_count == '0)
                begin
                    state_next = ST_IDLE;
                end
                else if (emit_go && is_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            emit_cnt_reg  <= '0;
            started_reg   <= 1'b0;
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_acc && (cfg.index == REG_ENABLE_MASK))
            begin
                mask_reg <= MASK_W'(cfg.data);
            end

            if (ctrl.load_start)
            begin
                started_reg <= 1'b1;
            end

            if (ctrl.load_check)
            begin
                step_reg     <= '0;
                emit_cnt_reg <= '0;
            end
            else
            begin
                if (ctrl.ring_step)
                begin
                    step_reg <= step_reg + CH_W'(1);
                end
                if (emit_go)
                begin
                    emit_cnt_reg <= emit_cnt_reg + CH_W'(1);
                end
            end

            if (emit_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (fire.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ctrl.load_check)
        begin
            now_reg <= req.now_time;
        end
        if (emit_go)
        begin
            out_chan_reg <= CHAN_OUT_W'(sel_idx);
            out_time_reg <= now_reg;
            out_last_reg <= is_last;
        end
    end

    assign fire.valid         = out_valid_reg;
    assign fire.fired_channel = out_chan_reg;
    assign fire.fire_time     = out_time_reg;
    assign fire.last_of_run   = out_last_reg;

endmodule

@@ src/mcps_checker.sv @@
// Port-level checker for the multi-channel periodic scheduler, with its bind.
// Depends on mcps_pkg and multi_channel_periodic_scheduler_macros.svh.
`timescale 1ns / 1ps

`include "multi_channel_periodic_scheduler_macros.svh"

module mcps_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            req_valid,
    input logic                            req_ready,
    input logic                            fire_valid,
    input logic                            fire_ready,
    input logic [mcps_pkg::CHAN_OUT_W-1:0] fire_fired_channel,
    input mcps_pkg::tick_t                 fire_fire_time,
    input logic                            fire_last_of_run
);
    import mcps_pkg::*;

    // a stalled firing holds its transaction
    `MCPS_ASSERT_NEXT(a_fire_hold, clk, rst_n, fire_valid && !fire_ready, fire_valid && $stable(fire_fired_channel) && $stable(fire_fire_time) && $stable(fire_last_of_run))

    // more firings of the same run are pending, so no new request is taken
    `MCPS_ASSERT_IMPLY(a_busy_mid_run, clk, rst_n, fire_valid && !fire_last_of_run, !req_ready)

    // a new firing never appears on the edge right after a request is taken
    `MCPS_ASSERT_NEXT(a_no_instant_fire, clk, rst_n, req_valid && req_ready, !fire_valid || $past(fire_valid))

endmodule

bind multi_channel_periodic_scheduler mcps_checker u_mcps_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .req_valid          (req.valid),
    .req_ready          (req.ready),
    .fire_valid         (fire.valid),
    .fire_ready         (fire.ready),
    .fire_fired_channel (fire.fired_channel),
    .fire_fire_time     (fire.fire_time),
    .fire_last_of_run   (fire.last_of_run)
);

@@ tb/tb_multi_channel_periodic_scheduler.sv @@
// Self-checking testbench for multi_channel_periodic_scheduler: directed and random requests,
// with the firings predicted in the bench and compared one by one against the block's output.
// Depends on mcps_pkg, mcps_ifs and the scheduler RTL.
`timescale 1ns / 1ps

module tb_multi_channel_periodic_scheduler;

    import mcps_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_GAP   = 16;   // long enough for a check with no firing to finish
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_ITEMS  = 23;

    typedef struct {
        logic  command;
        tick_t now;
    } request_t;

    // one predicted firing
    typedef struct packed {
        logic [CHAN_OUT_W-1:0] chan;
        tick_t                 stamp;
        logic                  last;
    } firing_t;

    logic clk;
    logic rst_n;

    mcps_req_if  req_bus ();
    mcps_fire_if fire_bus ();
    mcps_cfg_if  cfg_bus ();

    multi_channel_periodic_scheduler uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .fire  (fire_bus),
        .cfg   (cfg_bus)
    );

    // stimulus waiting for the driver, firings waiting for the monitor
    request_t request_q [$];
    firing_t  firing_q [$];

    // bench copy of the block's registers and state
    logic [MASK_W-1:0] en_mask;
    period_t           period_mirror [NUM_CHANNELS];
    tick_t             due_time [NUM_CHANNELS];
    logic              armed;

    logic        idle_en;     // random gaps on both sides when set
    logic        req_took;    // request transaction at the last rising edge
    int unsigned src_hold;
    int unsigned snk_hold;
    int unsigned n_errors;
    int unsigned n_starts;
    int unsigned n_checks;
    int unsigned n_firings;
    int unsigned n_cfg;
    int unsigned cycles;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TIMEOUT after %0d cycles, %0d firings still expected",
                     cycles, firing_q.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        n_errors++;
        $display("MISMATCH @%0t %s: got 0x%0h expected 0x%0h", $realtime, what, got, want);
    endtask

    // Work out the firings caused by one accepted request and queue them.
    task automatic apply_request(input logic cmd, input tick_t now);
        tick_t   lag [NUM_CHANNELS];
        logic    pend [NUM_CHANNELS];
        int      n_due;
        int      pick;
        firing_t f;
        if (cmd == CMD_START)
        begin
            // start re-arms every channel, enabled or not
            for (int c = 0; c < NUM_CHANNELS; c++)
                due_time[c] = now;
            armed = 1'b1;
            n_starts++;
            return;
        end
        n_checks++;
        if (!armed)
            return;
        n_due = 0;
        for (int c = 0; c < NUM_CHANNELS; c++)
        begin
            // wrap-safe compare: due when now - due is non-negative as a signed value
            lag[c]  = now - due_time[c];
            pend[c] = en_mask[c] && !lag[c][TIME_BITS-1];
            if (pend[c])
                n_due++;
        end
        for (int k = 0; k < n_due; k++)
        begin
            // oldest due time first; strict compare keeps ties on the lower index
            pick = -1;
            for (int c = 0; c < NUM_CHANNELS; c++)
                if (pend[c] && (pick < 0 || lag[c] > lag[pick]))
                    pick = c;
            pend[pick]     = 1'b0;
            due_time[pick] = due_time[pick] + tick_t'(period_mirror[pick]);
            f.chan  = CHAN_OUT_W'(pick);
            f.stamp = now;
            f.last  = (k == n_due - 1);
            firing_q.push_back(f);
        end
    endtask

    // Monitor: mirrors config writes, predicts on request transactions, checks firings.
    always @(posedge clk)
    begin
        firing_t want;
        req_took <= req_bus.valid && req_bus.ready;
        if (!rst_n)
        begin
            en_mask = '0;
            armed   = 1'b0;
            for (int c = 0; c < NUM_CHANNELS; c++)
            begin
                period_mirror[c] = period_t'(1);
                due_time[c]      = '0;
            end
        end
        else
        begin
            if (cfg_bus.valid && cfg_bus.ready)
            begin
                n_cfg++;
                if (cfg_bus.index == REG_ENABLE_MASK)
                    en_mask = cfg_bus.data[MASK_W-1:0];
                else if (cfg_bus.index >= REG_PERIOD_BASE &&
                         cfg_bus.index < REG_PERIOD_BASE + NUM_PERIOD_REGS)
                    period_mirror[CH_W'(cfg_bus.index - REG_PERIOD_BASE)] = cfg_bus.data;
                // any other index has no register behind it
            end
            if (req_bus.valid && req_bus.ready)
                apply_request(req_bus.command, req_bus.now_time);
            if (fire_bus.valid && fire_bus.ready)
            begin
                n_firings++;
                if (firing_q.size() == 0)
                    report_mismatch("unexpected firing, channel", fire_bus.fired_channel, 0);
                else
                begin
                    want = firing_q.pop_front();
                    if (fire_bus.fired_channel !== want.chan)
                        report_mismatch("fired_channel", fire_bus.fired_channel, want.chan);
                    if (fire_bus.fire_time !== want.stamp)
                        report_mismatch("fire_time", fire_bus.fire_time, want.stamp);
                    if (fire_bus.last_of_run !== want.last)
                        report_mismatch("last_of_run", fire_bus.last_of_run, want.last);
                end
            end
        end
    end

    // Request driver: holds a transaction until taken, inserts random gaps between them.
    always @(negedge clk)
    begin
        request_t item;
        if (req_bus.valid && !req_took)
        begin
            // still waiting for ready
        end
        else if (src_hold > 0)
        begin
            req_bus.valid <= 1'b0;
            src_hold--;
        end
        else if (idle_en && $urandom_range(0, 5) == 0)
        begin
            req_bus.valid <= 1'b0;
            src_hold = $urandom_range(0, 12);
        end
        else if (request_q.size() > 0)
        begin
            item = request_q.pop_front();
            req_bus.valid    <= 1'b1;
            req_bus.command  <= item.command;
            req_bus.now_time <= item.now;
        end
        else
            req_bus.valid <= 1'b0;
    end

    // Firing sink: ready drops in random bursts while idling is on.
    always @(negedge clk)
    begin
        if (snk_hold > 0)
        begin
            fire_bus.ready <= 1'b0;
            snk_hold--;
        end
        else if (idle_en && $urandom_range(0, 7) == 0)
        begin
            fire_bus.ready <= 1'b0;
            snk_hold = $urandom_range(0, 12);
        end
        else
            fire_bus.ready <= 1'b1;
    end

    task automatic push_req(input logic cmd, input tick_t now);
        request_t item;
        item.command = cmd;
        item.now     = now;
        request_q.push_back(item);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // Drain everything queued, then give the block time to finish a check with no firing.
    task automatic settle();
        while (request_q.size() != 0 || req_bus.valid || firing_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_GAP) @(posedge clk);
    endtask

    function automatic period_t pick_period();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return {PERIOD_W{1'b1}};
        if (r == 2)
            return period_t'($urandom);
        return period_t'($urandom_range(1, 30));
    endfunction

    initial
    begin
        tick_t       t;
        int unsigned r;
        rst_n            = 1'b0;
        clk              = 1'b0;
        idle_en          = 1'b1;
        src_hold         = 0;
        snk_hold         = 0;
        n_errors         = 0;
        n_starts         = 0;
        n_checks         = 0;
        n_firings        = 0;
        n_cfg            = 0;
        cycles           = 0;
        req_took         = 1'b0;
        req_bus.valid    = 1'b0;
        req_bus.command  = CMD_START;
        req_bus.now_time = '0;
        fire_bus.ready   = 1'b0;
        cfg_bus.valid    = 1'b0;
        cfg_bus.index    = REG_ENABLE_MASK;
        cfg_bus.data     = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset values: check before start is dead, then mask 0 keeps everything quiet
        push_req(CMD_CHECK, 32'd5);
        push_req(CMD_START, 32'hFFFF_FFFF);
        push_req(CMD_CHECK, 32'h0000_0000);
        settle();

        // all channels on: unit period, max period, zero period, period 3
        write_reg(REG_ENABLE_MASK, 31'hF);
        write_reg(CFG_IDX_W'(REG_PERIOD_BASE + 0), 31'd1);
        write_reg(CFG_IDX_W'(REG_PERIOD_BASE + 1), 31'h7FFF_FFFF);
        write_reg(CFG_IDX_W'(REG_PERIOD_BASE + 2), 31'd0);
        write_reg(CFG_IDX_W'(REG_PERIOD_BASE + 3), 31'd3);
        write_reg(CFG_IDX_W'(5), 31'h7FFF_FFFF);   // no register here
        write_reg(CFG_IDX_W'(7), 31'h7FFF_FFFF);
        push_req(CMD_START, 32'hFFFF_FFF0);
        push_req(CMD_CHECK, 32'hFFFF_FFF0);   // four-way tie, index order
        push_req(CMD_CHECK, 32'hFFFF_FFF2);
        push_req(CMD_CHECK, 32'h0000_0010);   // across the wrap
        push_req(CMD_CHECK, 32'h0000_0010);   // catch-up, zero period fires again
        push_req(CMD_CHECK, 32'h9000_0000);   // most channels now far past due
        push_req(CMD_CHECK, 32'hFFFF_FFFF);
        settle();

        // channels 0 and 2 off: they must neither fire nor advance
        write_reg(REG_ENABLE_MASK, 31'hA);
        write_reg(CFG_IDX_W'(REG_PERIOD_BASE + 0), 31'h7FFF_FFFF);
        write_reg(CFG_IDX_W'(REG_PERIOD_BASE + 1), 31'd2);
        write_reg(CFG_IDX_W'(REG_PERIOD_BASE + 2), 31'h5555_5555);
        write_reg(CFG_IDX_W'(REG_PERIOD_BASE + 3), 31'h2AAA_AAAA);
        push_req(CMD_START, 32'h0000_0000);
        push_req(CMD_CHECK, 32'h0000_0000);
        push_req(CMD_CHECK, 32'h0000_0001);
        push_req(CMD_CHECK, 32'h0000_0006);
        push_req(CMD_CHECK, 32'h7FFF_FFFF);
        push_req(CMD_CHECK, 32'h8000_0000);
        settle();
        write_reg(REG_ENABLE_MASK, 31'hF);

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            // the last two phases run at full rate on both sides
            idle_en = (ph < RAND_PHASES - 2) ? ($urandom_range(0, 3) != 0) : 1'b0;
            write_reg(REG_ENABLE_MASK, CFG_DATA_W'($urandom_range(0, 15) |
                                                   $urandom_range(0, 15)));
            for (int c = 0; c < NUM_PERIOD_REGS; c++)
                write_reg(CFG_IDX_W'(REG_PERIOD_BASE + c), pick_period());
            if ($urandom_range(0, 2) == 0)
                write_reg(CFG_IDX_W'($urandom_range(5, 7)), CFG_DATA_W'($urandom));

            t = $urandom;
            if ($urandom_range(0, 3) == 0)
                t = 32'hFFFF_FF00 + $urandom_range(0, 255);
            push_req(CMD_START, t);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                r = $urandom_range(0, 99);
                if (r < 75)
                begin
                    t = t + $urandom_range(0, 40);       // regular ticks
                    push_req(CMD_CHECK, t);
                end
                else if (r < 83)
                begin
                    t = t + $urandom_range(41, 3000);    // longer stall, catch-up
                    push_req(CMD_CHECK, t);
                end
                else if (r < 89)
                begin
                    t = t + $urandom_range(0, 40);       // re-arm mid-stream
                    push_req(CMD_START, t);
                end
                else if (r < 95)
                    push_req(CMD_CHECK, tick_t'($urandom));   // stray time value
                else
                begin
                    t = t + 32'h8000_0000 + $urandom_range(0, 64);   // at least half the range
                    push_req(CMD_CHECK, t);
                end
            end
            settle();
        end

        $display("Covered %0d start and %0d check transactions, %0d firings, %0d config writes",
                 n_starts, n_checks, n_firings, n_cfg);
        $display("Directed wrap, tie, zero-period and far-past-due cases plus %0d random phases",
                 RAND_PHASES);
        if (n_errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+src
src/mcps_pkg.sv
src/mcps_ifs.sv
src/mcps_cell.sv
src/multi_channel_periodic_scheduler.sv
src/mcps_checker.sv
tb/tb_multi_channel_periodic_scheduler.sv
